/* rtl/lav_pkg.sv */
// ---------------------------------------------------------------------------
// lav_pkg
// Types and constants shared by the look-at view matrix pipeline.
// ---------------------------------------------------------------------------
package lav_pkg;

	// three components, x in [0]
	typedef logic [2:0][31:0] vec32_t;
	typedef logic [2:0][63:0] vec64_t;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_X = 2'd0,
		REG_UP_Y = 2'd1,
		REG_UP_Z = 2'd2
	} reg_idx_t;

	localparam logic [31:0] UP_X_RESET = 32'h0000_0000;
	localparam logic [31:0] UP_Y_RESET = 32'h0001_0000;
	localparam logic [31:0] UP_Z_RESET = 32'h0000_0000;

	// width of a root and of a quotient in the normaliser
	localparam int RT_W = 31;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} cam_t;

	typedef struct packed {
		logic signed [31:0] row0_col0;
		logic signed [31:0] row0_col1;
		logic signed [31:0] row0_col2;
		logic signed [31:0] row1_col0;
		logic signed [31:0] row1_col1;
		logic signed [31:0] row1_col2;
		logic signed [31:0] row2_col0;
		logic signed [31:0] row2_col1;
		logic signed [31:0] row2_col2;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} view_t;

endpackage

/* rtl/look_at_view_matrix.sv */
// ---------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix from eye and target, up vector held in
// configuration registers.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  cam      | in        | cam_valid/cam_stall  | cam_t: eye and target, Q16.16
//  view     | out       | view_valid/view_stall| view_t: Q2.30 axes, Q16.16 shift
//  cfg      | in        | cfg_we               | cfg_index, cfg_data (up vector)
//
//  One word a cycle sustained while view_stall is low; the pipeline has
//  three normalisers of 68 stages each (31-stage square root, 31-stage
//  dividers), two 2-stage cross products and a 3-stage translation unit.
//  Reset clears valid bits and loads the up vector (0, 1.0, 0). A stalled output
//  word holds units back to the first with an empty last stage; if none, cam_stall rises.
// ---------------------------------------------------------------------------
module look_at_view_matrix (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cam_valid,
	output logic                             cam_stall,
	input  lav_pkg::cam_t                    cam,
	output logic                             view_valid,
	input  logic                             view_stall,
	output lav_pkg::view_t                   view,
	input  logic                             cfg_we,
	input  logic [lav_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lav_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lav_pkg::*;

	vec32_t up_q;
	vec32_t eye_in;
	vec64_t dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= UP_X_RESET;
			up_q[1] <= UP_Y_RESET;
			up_q[2] <= UP_Z_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UP_X: up_q[0] <= cfg_data;
				REG_UP_Y: up_q[1] <= cfg_data;
				REG_UP_Z: up_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eye_in = {cam.eye_z, cam.eye_y, cam.eye_x};
	assign dir[0] = 64'(cam.target_x) - 64'(cam.eye_x);
	assign dir[1] = 64'(cam.target_y) - 64'(cam.eye_y);
	assign dir[2] = 64'(cam.target_z) - 64'(cam.eye_z);

	logic   n1_valid, n1_stall;
	vec32_t fwd1;
	vec32_t eye1;
	lav_norm #(.SIDE_W(96)) u_norm_fwd (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cam_valid), .in_stall(cam_stall),
		.in_vec(dir), .in_side(eye_in),
		.out_valid(n1_valid), .out_stall(n1_stall),
		.out_vec(fwd1), .out_side(eye1)
	);

	logic       c1_valid, c1_stall;
	vec64_t     rgt_raw;
	logic [191:0] side_c1;
	lav_cross #(.SIDE_W(192)) u_cross_rgt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(n1_valid), .in_stall(n1_stall),
		.a(up_q), .b(fwd1), .in_side({eye1, fwd1}),
		.out_valid(c1_valid), .out_stall(c1_stall),
		.out_vec(rgt_raw), .out_side(side_c1)
	);

	logic       n2_valid, n2_stall;
	vec32_t     rgt2;
	logic [191:0] side_n2;
	lav_norm #(.SIDE_W(192)) u_norm_rgt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c1_valid), .in_stall(c1_stall),
		.in_vec(rgt_raw), .in_side(side_c1),
		.out_valid(n2_valid), .out_stall(n2_stall),
		.out_vec(rgt2), .out_side(side_n2)
	);

	logic       c2_valid, c2_stall;
	vec64_t     upw_raw;
	logic [287:0] side_c2;
	lav_cross #(.SIDE_W(288)) u_cross_upw (
		.clk(clk), .arst_n(arst_n),
		.in_valid(n2_valid), .in_stall(n2_stall),
		.a(side_n2[95:0]), .b(rgt2), .in_side({side_n2, rgt2}),
		.out_valid(c2_valid), .out_stall(c2_stall),
		.out_vec(upw_raw), .out_side(side_c2)
	);

	logic       n3_valid, n3_stall;
	vec32_t     upw3;
	logic [287:0] side_n3;
	lav_norm #(.SIDE_W(288)) u_norm_upw (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c2_valid), .in_stall(c2_stall),
		.in_vec(upw_raw), .in_side(side_c2),
		.out_valid(n3_valid), .out_stall(n3_stall),
		.out_vec(upw3), .out_side(side_n3)
	);

	// side layout: eye, forward, right from the top down
	lav_shift u_shift (
		.clk(clk), .arst_n(arst_n),
		.in_valid(n3_valid), .in_stall(n3_stall),
		.eye(side_n3[287:192]), .rgt(side_n3[95:0]),
		.upw(upw3), .fwd(side_n3[191:96]),
		.out_valid(view_valid), .out_stall(view_stall),
		.out_word(view)
	);

	a_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		view_valid && view.row0_col2 == 0 && view.row1_col2 == 0 && view.row2_col2 == 0
		|-> view.row0_col0 == 0 && view.row1_col0 == 0 && view.row2_col0 == 0
		&& view.shift_z == 0)
		else $error("zero forward axis with non-zero right axis");

	a_rgt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		view_valid && view.row0_col0 == 0 && view.row1_col0 == 0 && view.row2_col0 == 0
		|-> view.row0_col1 == 0 && view.row1_col1 == 0 && view.row2_col1 == 0)
		else $error("zero right axis with non-zero upward axis");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!view_valid |-> !cam_stall)
		else $error("input stalled while output register empty");

	a_cfg_up_y: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_UP_Y |=> up_q[1] == $past(cfg_data))
		else $error("up_y write lost");

endmodule

/* rtl/lav_norm.sv */
// ---------------------------------------------------------------------------
// lav_norm
// Pipelined vector normaliser: scale to [2^29, 2^30), bit-per-stage square
// root, then three bit-per-stage dividers giving Q2.30 components.
// ---------------------------------------------------------------------------
module lav_norm #(
	parameter int SIDE_W = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lav_pkg::vec64_t   in_vec,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_stall,
	output lav_pkg::vec32_t   out_vec,
	output logic [SIDE_W-1:0] out_side
);
	import lav_pkg::*;

	localparam int NF = 6;
	localparam int NS = NF + 2 * RT_W;

	logic [NS-1:0] v_q;
	logic          en;

	assign en = !(v_q[NS-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], in_valid};
		end
	end

	function automatic logic [5:0] msb_pos(input logic [62:0] x);
		logic [5:0] p;
		p = '0;
		for (int b = 0; b < 63; b++) begin
			if (x[b]) p = 6'(b);
		end
		return p;
	endfunction

	// front stages
	logic [2:0][62:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [62:0]      m_s2;
	logic [5:0]       pos_s3;
	logic             zero_s3, zero_s4, zero_s5, zero_s6;
	logic [2:0][29:0] nm_s4, nm_s5, nm_s6;
	logic [2:0][59:0] sqr_s5;
	logic [63:0]      sum_s6;

	logic [2:0][62:0] mag_in;
	logic [2:0][62:0] nm_sh;
	logic [62:0]      m_ab;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag_in[c] = in_vec[c][63] ? 63'(-in_vec[c]) : in_vec[c][62:0];
		end
		m_ab = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		for (int c = 0; c < 3; c++) begin
			if (pos_s3 >= 6'd30) begin
				nm_sh[c] = mag_s3[c] >> (pos_s3 - 6'd29);
			end else begin
				nm_sh[c] = mag_s3[c] << (6'd29 - pos_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_s1[c] <= mag_in[c];
				neg_s1[c] <= in_vec[c][63];
				sqr_s5[c] <= 60'(nm_s4[c] * nm_s4[c]);
			end
			side_s1 <= in_side;
			m_s2 <= (m_ab > mag_s1[2]) ? m_ab : mag_s1[2];
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			side_s2 <= side_s1;
			pos_s3 <= msb_pos(m_s2);
			zero_s3 <= (m_s2 == '0);
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			side_s3 <= side_s2;
			for (int c = 0; c < 3; c++) begin
				nm_s4[c] <= nm_sh[c][29:0];
			end
			zero_s4 <= zero_s3;
			neg_s4 <= neg_s3;
			side_s4 <= side_s3;
			nm_s5 <= nm_s4;
			zero_s5 <= zero_s4;
			neg_s5 <= neg_s4;
			side_s5 <= side_s4;
			sum_s6 <= 64'(sqr_s5[0]) + 64'(sqr_s5[1]) + 64'(sqr_s5[2]);
			nm_s6 <= nm_s5;
			zero_s6 <= zero_s5;
			neg_s6 <= neg_s5;
			side_s6 <= side_s5;
		end
	end

	// square root stages, one root bit each
	logic [63:0]       sq_rem_s  [RT_W];
	logic [RT_W-1:0]   sq_root_s [RT_W];
	logic [2:0][29:0]  sq_nm_s   [RT_W];
	logic [2:0]        sq_neg_s  [RT_W];
	logic              sq_zero_s [RT_W];
	logic [SIDE_W-1:0] sq_side_s [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_sq
		localparam int I = RT_W - 1 - k;
		logic [63:0]       rem_in, trial;
		logic [RT_W-1:0]   root_in;
		logic [2:0][29:0]  nm_in;
		logic [2:0]        neg_in;
		logic              zero_in;
		logic [SIDE_W-1:0] side_in;
		if (k == 0) begin : g_first
			assign rem_in = sum_s6;
			assign root_in = '0;
			assign nm_in = nm_s6;
			assign neg_in = neg_s6;
			assign zero_in = zero_s6;
			assign side_in = side_s6;
		end else begin : g_next
			assign rem_in = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign nm_in = sq_nm_s[k-1];
			assign neg_in = sq_neg_s[k-1];
			assign zero_in = sq_zero_s[k-1];
			assign side_in = sq_side_s[k-1];
		end
		assign trial = ({{(64-RT_W){1'b0}}, root_in} << (I + 1)) + (64'd1 << (2 * I));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					sq_rem_s[k] <= rem_in - trial;
					sq_root_s[k] <= root_in | (RT_W'(1) << I);
				end else begin
					sq_rem_s[k] <= rem_in;
					sq_root_s[k] <= root_in;
				end
				sq_nm_s[k] <= nm_in;
				sq_neg_s[k] <= neg_in;
				sq_zero_s[k] <= zero_in;
				sq_side_s[k] <= side_in;
			end
		end
	end

	// divider stages, one quotient bit each
	logic [2:0][63:0]     dv_rem_s  [RT_W];
	logic [2:0][RT_W-1:0] dv_q_s    [RT_W];
	logic [RT_W-1:0]      dv_len_s  [RT_W];
	logic [2:0]           dv_neg_s  [RT_W];
	logic                 dv_zero_s [RT_W];
	logic [SIDE_W-1:0]    dv_side_s [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_dv
		localparam int J = RT_W - 1 - k;
		logic [2:0][63:0]     rem_in;
		logic [2:0][RT_W-1:0] q_in;
		logic [RT_W-1:0]      len_in;
		logic [2:0]           neg_in;
		logic                 zero_in;
		logic [SIDE_W-1:0]    side_in;
		logic [63:0]          dsh;
		if (k == 0) begin : g_first
			logic [RT_W-1:0] len0;
			assign len0 = sq_root_s[RT_W-1];
			for (genvar c = 0; c < 3; c++) begin : g_num
				assign rem_in[c] = {4'd0, sq_nm_s[RT_W-1][c], 30'd0}
					+ {{(65-RT_W){1'b0}}, len0[RT_W-1:1]};
			end
			assign q_in = '0;
			assign len_in = len0;
			assign neg_in = sq_neg_s[RT_W-1];
			assign zero_in = sq_zero_s[RT_W-1];
			assign side_in = sq_side_s[RT_W-1];
		end else begin : g_next
			assign rem_in = dv_rem_s[k-1];
			assign q_in = dv_q_s[k-1];
			assign len_in = dv_len_s[k-1];
			assign neg_in = dv_neg_s[k-1];
			assign zero_in = dv_zero_s[k-1];
			assign side_in = dv_side_s[k-1];
		end
		assign dsh = {{(64-RT_W){1'b0}}, len_in} << J;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					if (rem_in[c] >= dsh) begin
						dv_rem_s[k][c] <= rem_in[c] - dsh;
						dv_q_s[k][c] <= q_in[c] | (RT_W'(1) << J);
					end else begin
						dv_rem_s[k][c] <= rem_in[c];
						dv_q_s[k][c] <= q_in[c];
					end
				end
				dv_len_s[k] <= len_in;
				dv_neg_s[k] <= neg_in;
				dv_zero_s[k] <= zero_in;
				dv_side_s[k] <= side_in;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dv_zero_s[RT_W-1]) begin
				out_vec[c] = '0;
			end else if (dv_neg_s[RT_W-1][c]) begin
				out_vec[c] = -{1'b0, dv_q_s[RT_W-1][c]};
			end else begin
				out_vec[c] = {1'b0, dv_q_s[RT_W-1][c]};
			end
		end
	end
	assign out_side = dv_side_s[RT_W-1];

endmodule

/* rtl/lav_cross.sv */
// ---------------------------------------------------------------------------
// lav_cross
// Two-stage exact cross product a x b of 32-bit signed vectors.
// ---------------------------------------------------------------------------
module lav_cross #(
	parameter int SIDE_W = 192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lav_pkg::vec32_t   a,
	input  lav_pkg::vec32_t   b,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_stall,
	output lav_pkg::vec64_t   out_vec,
	output logic [SIDE_W-1:0] out_side
);
	import lav_pkg::*;

	logic [1:0] v_q;
	logic       en;
	logic signed [5:0][63:0] p_s1;
	logic [SIDE_W-1:0] side_s1, side_s2;
	vec64_t r_s2;

	assign en = !(v_q[1] && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= $signed(a[1]) * $signed(b[2]);
			p_s1[1] <= $signed(a[2]) * $signed(b[1]);
			p_s1[2] <= $signed(a[2]) * $signed(b[0]);
			p_s1[3] <= $signed(a[0]) * $signed(b[2]);
			p_s1[4] <= $signed(a[0]) * $signed(b[1]);
			p_s1[5] <= $signed(a[1]) * $signed(b[0]);
			side_s1 <= in_side;
			r_s2[0] <= p_s1[0] - p_s1[1];
			r_s2[1] <= p_s1[2] - p_s1[3];
			r_s2[2] <= p_s1[4] - p_s1[5];
			side_s2 <= side_s1;
		end
	end

	assign out_vec = r_s2;
	assign out_side = side_s2;

endmodule

/* rtl/lav_shift.sv */
// ---------------------------------------------------------------------------
// lav_shift
// Translation row: -(eye . axis), rounded to Q16.16 and saturated; holds
// the finished matrix in the output register.
// ---------------------------------------------------------------------------
module lav_shift (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lav_pkg::vec32_t eye,
	input  lav_pkg::vec32_t rgt,
	input  lav_pkg::vec32_t upw,
	input  lav_pkg::vec32_t fwd,
	output logic            out_valid,
	input  logic            out_stall,
	output lav_pkg::view_t  out_word
);
	import lav_pkg::*;

	logic [2:0] v_q;
	logic       en;
	logic signed [2:0][2:0][63:0] prod_s1;
	logic signed [2:0][63:0] neg_s2;
	vec32_t rgt_s1, upw_s1, fwd_s1, rgt_s2, upw_s2, fwd_s2;
	view_t  word_s3;
	logic signed [2:0][31:0] sat;

	assign en = !(v_q[2] && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	always_comb begin
		logic signed [63:0] rv, qv;
		for (int k = 0; k < 3; k++) begin
			rv = neg_s2[k] + 64'sd536870912;
			qv = rv >>> 30;
			if (qv > 64'sd2147483647) begin
				sat[k] = 32'h7fff_ffff;
			end else if (qv < -64'sd2147483648) begin
				sat[k] = 32'h8000_0000;
			end else begin
				sat[k] = qv[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[0][i] <= $signed(eye[i]) * $signed(rgt[i]);
				prod_s1[1][i] <= $signed(eye[i]) * $signed(upw[i]);
				prod_s1[2][i] <= $signed(eye[i]) * $signed(fwd[i]);
			end
			rgt_s1 <= rgt;
			upw_s1 <= upw;
			fwd_s1 <= fwd;
			for (int k = 0; k < 3; k++) begin
				neg_s2[k] <= -(prod_s1[k][0] + prod_s1[k][1] + prod_s1[k][2]);
			end
			rgt_s2 <= rgt_s1;
			upw_s2 <= upw_s1;
			fwd_s2 <= fwd_s1;
			word_s3.row0_col0 <= rgt_s2[0];
			word_s3.row0_col1 <= upw_s2[0];
			word_s3.row0_col2 <= fwd_s2[0];
			word_s3.row1_col0 <= rgt_s2[1];
			word_s3.row1_col1 <= upw_s2[1];
			word_s3.row1_col2 <= fwd_s2[1];
			word_s3.row2_col0 <= rgt_s2[2];
			word_s3.row2_col1 <= upw_s2[2];
			word_s3.row2_col2 <= fwd_s2[2];
			word_s3.shift_x <= sat[0];
			word_s3.shift_y <= sat[1];
			word_s3.shift_z <= sat[2];
		end
	end

	assign out_word = word_s3;

endmodule
